/* rtl/byte_budget_lru_cache_table_unit_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the byte budget LRU cache table unit
// Shared property forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef BYTE_BUDGET_LRU_CACHE_TABLE_UNIT_DEFINES_SVH
`define BYTE_BUDGET_LRU_CACHE_TABLE_UNIT_DEFINES_SVH

// same-cycle implication
`define BBC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/bbc_pkg.sv */
// ----------------------------------------------------------------------------
// bbc_pkg
// Types, codes and constants shared by the cache table unit.
// ----------------------------------------------------------------------------
`default_nettype none
package bbc_pkg;

    localparam int DEF_ENTRIES = 16;
    localparam int KEY_W       = 32;
    localparam int SIZE_W      = 32;
    localparam int TOTAL_W     = 36;
    localparam int FUNC_W      = 3;
    localparam int STAT_W      = 4;
    localparam int BUDGET_W    = 16;
    localparam int MIB_SHIFT   = 20;

    localparam logic [FUNC_W-1:0] FN_GET   = 3'd0;
    localparam logic [FUNC_W-1:0] FN_QUERY = 3'd1;
    localparam logic [FUNC_W-1:0] FN_PUT   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_CLEAR = 3'd3;
    localparam logic [FUNC_W-1:0] FN_TRIM  = 3'd4;

    localparam logic [STAT_W-1:0] ST_EVICTED = 4'd0;
    localparam logic [STAT_W-1:0] ST_HIT     = 4'd1;
    localparam logic [STAT_W-1:0] ST_MISS    = 4'd2;
    localparam logic [STAT_W-1:0] ST_STORED  = 4'd3;
    localparam logic [STAT_W-1:0] ST_PRESENT = 4'd4;
    localparam logic [STAT_W-1:0] ST_IGNORED = 4'd5;
    localparam logic [STAT_W-1:0] ST_FULL    = 4'd6;
    localparam logic [STAT_W-1:0] ST_CLEARED = 4'd7;
    localparam logic [STAT_W-1:0] ST_TRIMMED = 4'd8;

    localparam logic [BUDGET_W-1:0] RESET_BUDGET_MB = 16'd512;
    localparam logic [TOTAL_W-1:0]  DEFAULT_BUDGET  = 36'h0_2000_0000;
    localparam logic [TOTAL_W-1:0]  TOTAL_MAX       = {TOTAL_W{1'b1}};

    typedef logic [1:0] emit_kind_t;
    localparam emit_kind_t EK_ADDR  = 2'd0;
    localparam emit_kind_t EK_HIT   = 2'd1;
    localparam emit_kind_t EK_EVICT = 2'd2;
    localparam emit_kind_t EK_ZERO  = 2'd3;

    typedef struct packed {
        logic              capture;
        logic              scan_init;
        logic              scan_en;
        logic              touch;
        logic              evict;
        logic              store;
        logic              clear;
        logic              emit;
        logic              last;
        logic [STAT_W-1:0] stat;
        emit_kind_t        kind;
    } cmd_t;

    typedef struct packed {
        logic              out_full;
        logic              scan_last;
        logic              match_found;
        logic              match_pinned;
        logic              free_found;
        logic              lru_found;
        logic              over;
        logic              size_zero;
        logic              pin;
        logic [FUNC_W-1:0] func;
    } sts_t;

endpackage
`default_nettype wire

/* rtl/bbc_in_if.sv */
// ----------------------------------------------------------------------------
// bbc_in_if
// Request channel: valid/ready handshake with request payload.
// ----------------------------------------------------------------------------
`default_nettype none
interface bbc_in_if
    import bbc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key;
    logic [SIZE_W-1:0] size_bytes;
    logic              pinned;

    modport source (output valid, output func, output key, output size_bytes,
                    output pinned, input ready);
    modport sink   (input valid, input func, input key, input size_bytes,
                    input pinned, output ready);
endinterface
`default_nettype wire

/* rtl/bbc_out_if.sv */
// ----------------------------------------------------------------------------
// bbc_out_if
// Result channel: valid/ready handshake with result payload.
// ----------------------------------------------------------------------------
`default_nettype none
interface bbc_out_if
    import bbc_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [STAT_W-1:0]  status;
    logic [KEY_W-1:0]   key_out;
    logic [SIZE_W-1:0]  size_out;
    logic [TOTAL_W-1:0] total_bytes;
    logic               last;

    modport source (output valid, output status, output key_out, output size_out,
                    output total_bytes, output last, input ready);
    modport sink   (input valid, input status, input key_out, input size_out,
                    input total_bytes, input last, output ready);
endinterface
`default_nettype wire

/* rtl/bbc_ctrl.sv */
// ----------------------------------------------------------------------------
// bbc_ctrl
// Sequencer: dispatches requests, runs table scans, decides evictions.
// ----------------------------------------------------------------------------
`default_nettype none
`include "byte_budget_lru_cache_table_unit_defines.svh"
module bbc_ctrl
    import bbc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_START  = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;
    localparam logic [1:0] S_DECIDE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_START;
                end
            end
            S_START:
            begin
                if (sts.func == FN_CLEAR)
                begin
                    if (!sts.out_full)
                    begin
                        cmd.clear  = 1'b1;
                        cmd.emit   = 1'b1;
                        cmd.last   = 1'b1;
                        cmd.stat   = ST_CLEARED;
                        cmd.kind   = EK_ZERO;
                        state_next = S_IDLE;
                    end
                end
                else if (!(sts.func inside {FN_GET, FN_QUERY, FN_PUT, FN_TRIM}) ||
                         (sts.func == FN_PUT && sts.size_zero))
                begin
                    if (!sts.out_full)
                    begin
                        cmd.emit   = 1'b1;
                        cmd.last   = 1'b1;
                        cmd.stat   = ST_IGNORED;
                        cmd.kind   = EK_ADDR;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_en = 1'b1;
                if (sts.scan_last)
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (!sts.out_full)
                begin
                    cmd.emit = 1'b1;
                    cmd.last = 1'b1;
                    cmd.kind = EK_ADDR;
                    state_next = S_IDLE;
                    case (sts.func)
                        FN_GET, FN_QUERY:
                        begin
                            if (sts.match_found)
                            begin
                                cmd.stat  = ST_HIT;
                                cmd.kind  = EK_HIT;
                                cmd.touch = (sts.func == FN_GET) && !sts.match_pinned;
                            end
                            else
                                cmd.stat = ST_MISS;
                        end
                        FN_PUT:
                        begin
                            if (sts.match_found)
                                cmd.stat = ST_PRESENT;
                            else if (sts.lru_found &&
                                     ((!sts.pin && sts.over) || !sts.free_found))
                            begin
                                // evict one, then rescan for the next victim
                                cmd.evict     = 1'b1;
                                cmd.last      = 1'b0;
                                cmd.stat      = ST_EVICTED;
                                cmd.kind      = EK_EVICT;
                                cmd.scan_init = 1'b1;
                                state_next    = S_SCAN;
                            end
                            else if (sts.free_found)
                            begin
                                cmd.store = 1'b1;
                                cmd.stat  = ST_STORED;
                            end
                            else
                                cmd.stat = ST_FULL;
                        end
                        default:
                        begin
                            if (sts.over && sts.lru_found)
                            begin
                                cmd.evict     = 1'b1;
                                cmd.last      = 1'b0;
                                cmd.stat      = ST_EVICTED;
                                cmd.kind      = EK_EVICT;
                                cmd.scan_init = 1'b1;
                                state_next    = S_SCAN;
                            end
                            else
                            begin
                                cmd.stat = ST_TRIMMED;
                                cmd.kind = EK_ZERO;
                            end
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    `BBC_ASSERT_NOW(a_emit_slot_free, clk, rst_n, cmd.emit, !sts.out_full,
        "result emitted while output register still occupied")
    `BBC_ASSERT_NOW(a_store_has_slot, clk, rst_n, cmd.store, sts.free_found,
        "store without a free slot")
    `BBC_ASSERT_NOW(a_evict_has_victim, clk, rst_n, cmd.evict, sts.lru_found,
        "eviction without an unpinned victim")
    `BBC_ASSERT_NEXT(a_last_to_idle, clk, rst_n, cmd.emit && cmd.last,
        state_reg == S_IDLE, "final result did not return to idle")

endmodule
`default_nettype wire

/* rtl/bbc_dp.sv */
// ----------------------------------------------------------------------------
// bbc_dp
// Entry table, scan trackers, byte total, budget and output register.
// ----------------------------------------------------------------------------
`default_nettype none
module bbc_dp
    import bbc_pkg::*;
#(
    parameter int ENTRIES = DEF_ENTRIES
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cmd_t                cmd,
    output sts_t                     sts,
    input  wire logic                cfg_wr_en,
    input  wire logic [BUDGET_W-1:0] cfg_wr_data,
    input  wire logic [FUNC_W-1:0]   in_func,
    input  wire logic [KEY_W-1:0]    in_key,
    input  wire logic [SIZE_W-1:0]   in_size_bytes,
    input  wire logic                in_pinned,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [STAT_W-1:0]        out_status,
    output logic [KEY_W-1:0]         out_key,
    output logic [SIZE_W-1:0]        out_size,
    output logic [TOTAL_W-1:0]       out_total,
    output logic                     out_last
);

    localparam int IDX_W = $clog2(ENTRIES);

    // entry table
    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] pinned_reg;
    logic [KEY_W-1:0]   key_mem  [ENTRIES];
    logic [SIZE_W-1:0]  size_mem [ENTRIES];
    logic [IDX_W-1:0]   rank_reg [ENTRIES];

    // request
    logic [FUNC_W-1:0] func_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [SIZE_W-1:0] size_reg;
    logic              pin_reg;

    // scan trackers
    logic [IDX_W-1:0]  idx_reg;
    logic              match_found_reg;
    logic [IDX_W-1:0]  match_idx_reg;
    logic [SIZE_W-1:0] match_size_reg;
    logic [IDX_W-1:0]  match_rank_reg;
    logic              match_pinned_reg;
    logic              free_found_reg;
    logic [IDX_W-1:0]  free_idx_reg;
    logic              lru_found_reg;
    logic [IDX_W-1:0]  lru_idx_reg;
    logic [IDX_W-1:0]  lru_rank_reg;
    logic [KEY_W-1:0]  lru_key_reg;
    logic [SIZE_W-1:0] lru_size_reg;

    logic [TOTAL_W-1:0]  total_reg;
    logic [TOTAL_W-1:0]  total_next;
    logic [BUDGET_W-1:0] budget_reg;
    logic                out_valid_reg;

    logic               cur_valid;
    logic               cur_pinned;
    logic [KEY_W-1:0]   cur_key;
    logic [SIZE_W-1:0]  cur_size;
    logic [IDX_W-1:0]   cur_rank;
    logic [TOTAL_W-1:0] budget_bytes;
    logic [SIZE_W-1:0]  need;
    logic [TOTAL_W:0]   need_sum;
    logic [TOTAL_W:0]   put_sum;

    assign cur_valid  = valid_reg[idx_reg];
    assign cur_pinned = pinned_reg[idx_reg];
    assign cur_key    = key_mem[idx_reg];
    assign cur_size   = size_mem[idx_reg];
    assign cur_rank   = rank_reg[idx_reg];

    assign budget_bytes = (budget_reg == '0) ? DEFAULT_BUDGET
                                             : {budget_reg, {MIB_SHIFT{1'b0}}};
    assign need     = (func_reg == FN_TRIM) ? '0 : size_reg;
    assign need_sum = {1'b0, total_reg} + (TOTAL_W+1)'(need);
    assign put_sum  = {1'b0, total_reg} + (TOTAL_W+1)'(size_reg);

    always_comb
    begin
        total_next = total_reg;
        if (cmd.clear)
            total_next = '0;
        else if (cmd.evict)
            total_next = (total_reg >= TOTAL_W'(lru_size_reg))
                       ? total_reg - TOTAL_W'(lru_size_reg) : '0;
        else if (cmd.store)
            total_next = put_sum[TOTAL_W] ? TOTAL_MAX : put_sum[TOTAL_W-1:0];
    end

    always_comb
    begin
        sts              = '0;
        sts.out_full     = out_valid_reg;
        sts.scan_last    = (idx_reg == IDX_W'(ENTRIES-1));
        sts.match_found  = match_found_reg;
        sts.match_pinned = match_pinned_reg;
        sts.free_found   = free_found_reg;
        sts.lru_found    = lru_found_reg;
        sts.over         = need_sum > {1'b0, budget_bytes};
        sts.size_zero    = (size_reg == '0);
        sts.pin          = pin_reg;
        sts.func         = func_reg;
    end

    // request capture, table and result payload; no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg <= in_func;
            key_reg  <= in_key;
            size_reg <= in_size_bytes;
            pin_reg  <= in_pinned;
        end
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (cmd.touch && valid_reg[i] && !pinned_reg[i] &&
                rank_reg[i] < match_rank_reg)
                rank_reg[i] <= rank_reg[i] + 1'b1;
            if (cmd.store && !pin_reg && valid_reg[i] && !pinned_reg[i])
                rank_reg[i] <= rank_reg[i] + 1'b1;
        end
        if (cmd.touch)
            rank_reg[match_idx_reg] <= '0;
        if (cmd.store)
        begin
            key_mem[free_idx_reg]    <= key_reg;
            size_mem[free_idx_reg]   <= size_reg;
            pinned_reg[free_idx_reg] <= pin_reg;
            rank_reg[free_idx_reg]   <= '0;
        end
        // scan payload trackers
        if (cmd.scan_en)
        begin
            idx_reg <= idx_reg + 1'b1;
            if (cur_valid && cur_key == key_reg && !match_found_reg)
            begin
                match_idx_reg    <= idx_reg;
                match_size_reg   <= cur_size;
                match_rank_reg   <= cur_rank;
                match_pinned_reg <= cur_pinned;
            end
            if (!cur_valid && !free_found_reg)
                free_idx_reg <= idx_reg;
            if (cur_valid && !cur_pinned && (!lru_found_reg || cur_rank > lru_rank_reg))
            begin
                lru_idx_reg  <= idx_reg;
                lru_rank_reg <= cur_rank;
                lru_key_reg  <= cur_key;
                lru_size_reg <= cur_size;
            end
        end
        if (cmd.scan_init)
            idx_reg <= '0;
        if (cmd.emit)
        begin
            out_status <= cmd.stat;
            out_total  <= total_next;
            out_last   <= cmd.last;
            case (cmd.kind)
                EK_ADDR:
                begin
                    out_key  <= key_reg;
                    out_size <= '0;
                end
                EK_HIT:
                begin
                    out_key  <= key_reg;
                    out_size <= match_size_reg;
                end
                EK_EVICT:
                begin
                    out_key  <= lru_key_reg;
                    out_size <= lru_size_reg;
                end
                default:
                begin
                    out_key  <= '0;
                    out_size <= '0;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= '0;
            total_reg       <= '0;
            budget_reg      <= RESET_BUDGET_MB;
            out_valid_reg   <= 1'b0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            lru_found_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                budget_reg <= cfg_wr_data;
            total_reg <= total_next;
            if (cmd.clear)
                valid_reg <= '0;
            else if (cmd.evict)
                valid_reg[lru_idx_reg] <= 1'b0;
            else if (cmd.store)
                valid_reg[free_idx_reg] <= 1'b1;
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (cmd.scan_init)
            begin
                match_found_reg <= 1'b0;
                free_found_reg  <= 1'b0;
                lru_found_reg   <= 1'b0;
            end
            else if (cmd.scan_en)
            begin
                if (cur_valid && cur_key == key_reg)
                    match_found_reg <= 1'b1;
                if (!cur_valid)
                    free_found_reg <= 1'b1;
                if (cur_valid && !cur_pinned)
                    lru_found_reg <= 1'b1;
            end
        end
    end

    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

/* rtl/byte_budget_lru_cache_table_unit.sv */
// Clear and ignored requests are answered from the start state; get, size query and
//   put scan the whole table first, then decide in the decide state.
// Each eviction adds one full table scan: the scan walks one entry per cycle
//   through the single table read port.
// Throughput: one request at a time, taken again once the final result is in the
//   output register. Reset: async active-low, table empty, total 0, budget 512 MiB.
// ----------------------------------------------------------------------------
// byte_budget_lru_cache_table_unit
// Size-aware LRU cache bookkeeping with pinning and a MiB byte budget.
// ----------------------------------------------------------------------------
`default_nettype none
module byte_budget_lru_cache_table_unit
    import bbc_pkg::*;
#(
    parameter int ENTRIES = DEF_ENTRIES
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_wr_en,
    input  wire logic [BUDGET_W-1:0] cfg_wr_data,
    bbc_in_if.sink                   in_ch,
    bbc_out_if.source                out_ch
);

    // command and status between sequencer and datapath
    cmd_t cmd;
    sts_t sts;

    // sequencer: owns input ready, scan pacing and eviction decisions
    bbc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: entry table, LRU/free/match trackers, total and result register
    bbc_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_func       (in_ch.func),
        .in_key        (in_ch.key),
        .in_size_bytes (in_ch.size_bytes),
        .in_pinned     (in_ch.pinned),
        .out_valid     (out_ch.valid),
        .out_ready     (out_ch.ready),
        .out_status    (out_ch.status),
        .out_key       (out_ch.key_out),
        .out_size      (out_ch.size_out),
        .out_total     (out_ch.total_bytes),
        .out_last      (out_ch.last)
    );

endmodule
`default_nettype wire

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the byte budget LRU cache table unit: random and
// directed requests, a scoreboard built from a cycle-free table predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module tb_top;
    import bbc_pkg::*;

    localparam int N_ENT      = DEF_ENTRIES;
    localparam int KEY_POOL   = 24;
    localparam int STALL_MAX  = 6000;
    localparam int HOLD_LEN   = 400;

    typedef struct {
        logic [FUNC_W-1:0] func;
        logic [KEY_W-1:0]  key;
        logic [SIZE_W-1:0] size;
        logic              pin;
    } req_t;

    typedef struct {
        logic [STAT_W-1:0]  status;
        logic [KEY_W-1:0]   key;
        logic [SIZE_W-1:0]  size;
        logic [TOTAL_W-1:0] total;
        logic               last;
    } resp_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [BUDGET_W-1:0] cfg_wr_data;

    bbc_in_if  in_ch ();
    bbc_out_if out_ch ();

    byte_budget_lru_cache_table_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch)
    );

    // requests waiting for the driver, and results the table must still produce
    req_t  req_q[$];
    resp_t resp_q[$];

    int tx_idle_pct;
    int rx_idle_pct;
    int pin_pct;
    int clear_pct;
    bit hold_go;
    bit hold_done;
    int hold_cnt;
    bit in_taken;
    int errors;
    int n_items;
    int n_results;
    int n_evicts;
    int n_full;
    int stall_cnt;

    // predictor copy of the table
    bit                 t_valid [N_ENT];
    logic [KEY_W-1:0]   t_key   [N_ENT];
    logic [SIZE_W-1:0]  t_size  [N_ENT];
    bit                 t_pin   [N_ENT];
    int                 t_rank  [N_ENT];
    logic [TOTAL_W-1:0] t_total;
    logic [BUDGET_W-1:0] t_budget;

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Table predictor
    // ------------------------------------------------------------------
    function automatic logic [TOTAL_W+1:0] budget_bytes();
        if (t_budget == '0)
            return {2'b00, DEFAULT_BUDGET};
        return {6'd0, t_budget, 16'd0} << (MIB_SHIFT - 16);
    endfunction

    function automatic void push_result(logic [STAT_W-1:0] st, logic [KEY_W-1:0] k,
                                        logic [SIZE_W-1:0] sz);
        resp_t r;
        r.status = st;
        r.key    = k;
        r.size   = sz;
        r.total  = t_total;
        r.last   = 1'b0;
        resp_q.push_back(r);
    endfunction

    function automatic int lookup_key(logic [KEY_W-1:0] k);
        for (int i = 0; i < N_ENT; i++)
            if (t_valid[i] && t_key[i] == k)
                return i;
        return -1;
    endfunction

    function automatic int oldest_unpinned();
        int best;
        best = -1;
        for (int i = 0; i < N_ENT; i++)
            if (t_valid[i] && !t_pin[i] && (best < 0 || t_rank[i] > t_rank[best]))
                best = i;
        return best;
    endfunction

    function automatic void drop_entry(int i);
        t_total    = (t_total >= {4'd0, t_size[i]}) ? t_total - {4'd0, t_size[i]} : '0;
        t_valid[i] = 1'b0;
        push_result(ST_EVICTED, t_key[i], t_size[i]);
    endfunction

    // evict least recent unpinned entries until total+need fits the budget
    function automatic void shrink_to_budget(logic [SIZE_W-1:0] need);
        int v;
        while ({2'b00, t_total} + {6'd0, need} > budget_bytes()) begin
            v = oldest_unpinned();
            if (v < 0)
                break;
            drop_entry(v);
        end
    endfunction

    function automatic void make_recent(int t);
        int r;
        r = t_rank[t];
        for (int i = 0; i < N_ENT; i++)
            if (t_valid[i] && !t_pin[i] && t_rank[i] < r)
                t_rank[i]++;
        t_rank[t] = 0;
    endfunction

    function automatic void insert_entry(logic [KEY_W-1:0] k, logic [SIZE_W-1:0] sz,
                                         bit pin);
        int slot;
        logic [TOTAL_W:0] sum;
        slot = -1;
        if (sz == '0) begin
            push_result(ST_IGNORED, k, '0);
            return;
        end
        if (lookup_key(k) >= 0) begin
            push_result(ST_PRESENT, k, '0);
            return;
        end
        if (!pin)
            shrink_to_budget(sz);
        for (int i = 0; i < N_ENT; i++)
            if (!t_valid[i]) begin
                slot = i;
                break;
            end
        if (slot < 0) begin
            slot = oldest_unpinned();
            if (slot < 0) begin
                push_result(ST_FULL, k, '0);
                return;
            end
            drop_entry(slot);
        end
        if (!pin)
            for (int i = 0; i < N_ENT; i++)
                if (t_valid[i] && !t_pin[i])
                    t_rank[i]++;
        t_valid[slot] = 1'b1;
        t_key[slot]   = k;
        t_size[slot]  = sz;
        t_pin[slot]   = pin;
        t_rank[slot]  = 0;
        sum = {1'b0, t_total} + {5'd0, sz};
        t_total = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
        push_result(ST_STORED, k, '0);
    endfunction

    // append the results one accepted request causes
    function automatic void predict_request(req_t rq);
        int i;
        case (rq.func)
            FN_GET, FN_QUERY:
            begin
                i = lookup_key(rq.key);
                if (i < 0)
                    push_result(ST_MISS, rq.key, '0);
                else
                begin
                    if (rq.func == FN_GET && !t_pin[i])
                        make_recent(i);
                    push_result(ST_HIT, rq.key, t_size[i]);
                end
            end
            FN_PUT:
                insert_entry(rq.key, rq.size, rq.pin);
            FN_CLEAR:
            begin
                for (int j = 0; j < N_ENT; j++)
                    t_valid[j] = 1'b0;
                t_total = '0;
                push_result(ST_CLEARED, '0, '0);
            end
            FN_TRIM:
            begin
                shrink_to_budget('0);
                push_result(ST_TRIMMED, '0, '0);
            end
            default:
                push_result(ST_IGNORED, rq.key, '0);
        endcase
        resp_q[resp_q.size()-1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Driver: change inputs on the falling edge, hold until taken
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        req_t rq;
        if (rst_n && (!in_ch.valid || in_taken))
        begin
            if (req_q.size() > 0 && $urandom_range(99) >= tx_idle_pct)
            begin
                rq = req_q.pop_front();
                in_ch.func       <= rq.func;
                in_ch.key        <= rq.key;
                in_ch.size_bytes <= rq.size;
                in_ch.pinned     <= rq.pin;
                in_ch.valid      <= 1'b1;
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // Receiver ready, with one long hold-off counted here
    always @(negedge clk)
    begin
        if (hold_go && !hold_done)
        begin
            hold_cnt  <= HOLD_LEN;
            hold_done <= 1'b1;
            out_ch.ready <= 1'b0;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt <= hold_cnt - 1;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // ------------------------------------------------------------------
    // Monitor: sample on the rising edge, predict and check
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        req_t  rq;
        resp_t ex;
        in_taken <= in_ch.valid && in_ch.ready;
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            rq.func = in_ch.func;
            rq.key  = in_ch.key;
            rq.size = in_ch.size_bytes;
            rq.pin  = in_ch.pinned;
            predict_request(rq);
            n_items++;
        end
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            n_results++;
            if (out_ch.status == ST_EVICTED)
                n_evicts++;
            if (out_ch.status == ST_FULL)
                n_full++;
            if (resp_q.size() == 0)
            begin
                $error("unexpected result status=%0d key=%h", out_ch.status, out_ch.key_out);
                errors++;
            end
            else
            begin
                ex = resp_q.pop_front();
                if (out_ch.status !== ex.status)
                begin
                    $error("status: expected %0d actual %0d", ex.status, out_ch.status);
                    errors++;
                end
                if (out_ch.key_out !== ex.key)
                begin
                    $error("key_out: expected %h actual %h", ex.key, out_ch.key_out);
                    errors++;
                end
                if (out_ch.size_out !== ex.size)
                begin
                    $error("size_out: expected %h actual %h", ex.size, out_ch.size_out);
                    errors++;
                end
                if (out_ch.total_bytes !== ex.total)
                begin
                    $error("total_bytes: expected %h actual %h", ex.total,
                           out_ch.total_bytes);
                    errors++;
                end
                if (out_ch.last !== ex.last)
                begin
                    $error("last: expected %0b actual %0b", ex.last, out_ch.last);
                    errors++;
                end
            end
        end
    end

    // Watchdog: count cycles in which neither side moves an item
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_MAX)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic req_t mk(logic [FUNC_W-1:0] f, logic [KEY_W-1:0] k,
                                logic [SIZE_W-1:0] s, bit p);
        req_t rq;
        rq.func = f;
        rq.key  = k;
        rq.size = s;
        rq.pin  = p;
        return rq;
    endfunction

    // wait for a drained pipeline, then let the block settle
    task automatic wait_drained();
        while (req_q.size() > 0 || in_ch.valid || resp_q.size() > 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_budget(logic [BUDGET_W-1:0] v);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        t_budget     = v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic req_t random_request();
        req_t rq;
        int   pick;
        longint unsigned cap;
        pick = $urandom_range(99);
        if (pick < 45)
            rq.func = FN_PUT;
        else if (pick < 70)
            rq.func = FN_GET;
        else if (pick < 80)
            rq.func = FN_QUERY;
        else if (pick < 80 + clear_pct)
            rq.func = FN_CLEAR;
        else if (pick < 92)
            rq.func = FN_TRIM;
        else
            rq.func = 3'($urandom_range(7));
        // mostly a small key pool so gets hit and puts collide
        if ($urandom_range(9) == 0)
            rq.key = $urandom;
        else
            rq.key = 32'h5A00_0000 | $urandom_range(KEY_POOL - 1);
        cap = budget_bytes() / 3;
        if (cap > 64'hFFFF_FFFF)
            cap = 64'hFFFF_FFFF;
        pick = $urandom_range(19);
        if (pick == 0)
            rq.size = '0;
        else if (pick == 1)
            rq.size = $urandom;
        else
            rq.size = 32'($urandom_range(32'(cap), 1));
        rq.pin = ($urandom_range(99) < pin_pct);
        return rq;
    endfunction

    initial
    begin
        logic [BUDGET_W-1:0] budgets [6];
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        in_ch.valid = 1'b0;
        in_ch.func = '0;
        in_ch.key = '0;
        in_ch.size_bytes = '0;
        in_ch.pinned = 1'b0;
        out_ch.ready = 1'b0;
        tx_idle_pct = 14;
        rx_idle_pct = 46;
        pin_pct = 15;
        clear_pct = 3;
        hold_go = 1'b0;
        hold_done = 1'b0;
        hold_cnt = 0;
        in_taken = 1'b0;
        errors = 0;
        n_items = 0;
        n_results = 0;
        n_evicts = 0;
        n_full = 0;
        stall_cnt = 0;
        t_total = '0;
        t_budget = RESET_BUDGET_MB;
        for (int i = 0; i < N_ENT; i++)
        begin
            t_valid[i] = 1'b0;
            t_key[i]   = '0;
            t_size[i]  = '0;
            t_pin[i]   = 1'b0;
            t_rank[i]  = 0;
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: 1 MiB budget so a few hundred KiB forces eviction
        write_budget(16'd1);
        req_q.push_back(mk(FN_GET, 32'h0, 32'h0, 1'b0));               // miss
        req_q.push_back(mk(FN_PUT, 32'h0, 32'h0, 1'b0));               // zero size
        req_q.push_back(mk(FN_PUT, 32'hFFFF_FFFF, 32'd600_000, 1'b0));
        req_q.push_back(mk(FN_PUT, 32'hFFFF_FFFF, 32'd5, 1'b0));       // present
        req_q.push_back(mk(FN_GET, 32'hFFFF_FFFF, 32'h0, 1'b0));       // hit
        req_q.push_back(mk(FN_QUERY, 32'hFFFF_FFFF, 32'h0, 1'b0));
        req_q.push_back(mk(FN_PUT, 32'h1, 32'd600_000, 1'b0));         // evicts
        req_q.push_back(mk(FN_PUT, 32'h2, 32'hFFFF_FFFF, 1'b1));       // pinned over
        req_q.push_back(mk(FN_GET, 32'h2, 32'h0, 1'b1));               // pinned hit
        req_q.push_back(mk(FN_TRIM, 32'h0, 32'h0, 1'b0));
        req_q.push_back(mk(3'd5, 32'hA5A5_5A5A, 32'hFFFF_FFFF, 1'b1));
        req_q.push_back(mk(3'd6, 32'h1234_5678, 32'h0, 1'b0));
        req_q.push_back(mk(3'd7, 32'hFFFF_FFFF, 32'h1, 1'b0));
        req_q.push_back(mk(FN_CLEAR, 32'h0, 32'h0, 1'b0));
        wait_drained();

        // full table: 17 tiny unpinned puts, then pinned ones until full
        write_budget(16'hFFFF);
        for (int i = 0; i < 17; i++)
            req_q.push_back(mk(FN_PUT, 32'h100 + i, 32'd1, 1'b0));
        for (int i = 0; i < 17; i++)
            req_q.push_back(mk(FN_PUT, 32'h200 + i, 32'hFFFF_FFFF, 1'b1));
        req_q.push_back(mk(FN_CLEAR, 32'h0, 32'h0, 1'b0));
        wait_drained();

        // random phases across budgets, extremes included
        budgets = '{16'd4, 16'd1, 16'd0, 16'hFFFF, 16'd2, 16'd512};
        for (int ph = 0; ph < 6; ph++)
        begin
            tx_idle_pct = (ph < 2) ? 14 : (ph < 4) ? 46 : 0;
            rx_idle_pct = (ph < 2) ? 46 : (ph < 4) ? 14 : 0;
            pin_pct     = (budgets[ph] == 16'hFFFF) ? 50 : 15;
            clear_pct   = (budgets[ph] == 16'hFFFF) ? 1 : 3;
            write_budget(budgets[ph]);
            for (int i = 0; i < 70; i++)
            begin
                req_q.push_back(random_request());
                // fill the block while the receiver holds off
                if (ph == 1 && i == 20)
                    hold_go = 1'b1;
                if (req_q.size() > 8)
                    while (req_q.size() > 2)
                        @(posedge clk);
            end
            wait_drained();
        end

        $display("Run covered %0d requests and %0d results (%0d evictions, %0d table full)",
                 n_items, n_results, n_evicts, n_full);
        $display("over six budget settings with mixed idling and a long output stall");
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
